// File: hw/rtl/ebfr_pkg.sv
// ----------------------------------------------------------------------------
// ebfr_pkg
// Codes, modes and shared types of the escaped byte frame receiver.
// ----------------------------------------------------------------------------
package ebfr_pkg;

    // line control codes
    localparam logic [7:0] CODE_RESET   = 8'h42;
    localparam logic [7:0] CODE_ESC     = 8'h23;
    localparam logic [7:0] CODE_XON     = 8'h11;
    localparam logic [7:0] CODE_XOFF    = 8'h13;

    // escaped commands
    localparam logic [7:0] ESC_DATA_MIN = 8'h01;
    localparam logic [7:0] ESC_DATA_MAX = 8'h04;
    localparam logic [7:0] ESC_MSG      = 8'h14;
    localparam logic [7:0] ESC_SSTART   = 8'h15;
    localparam logic [7:0] ESC_SSTOP    = 8'h16;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_STREAM  = 2'd1,
        MODE_MESSAGE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        KIND_STREAM_DATA  = 3'd0,
        KIND_MSG_BYTE     = 3'd1,
        KIND_STREAM_START = 3'd2,
        KIND_STREAM_STOP  = 3'd3,
        KIND_EMPTY_MSG    = 3'd4
    } t_kind;

    typedef struct packed {
        logic        esc;
        t_mode       mode;
        logic [16:0] idx;
        logic [15:0] len;
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [15:0] payload_offset;
        logic [15:0] message_length;
        logic        last;
    } t_result;

    // escaped 1..4 -> data byte; 4 has low bits 00
    function automatic logic [7:0] unescape(input logic [1:0] code);
        logic [7:0] res;
        case (code)
            2'd1:    res = CODE_RESET;
            2'd2:    res = CODE_ESC;
            2'd3:    res = CODE_XON;
            default: res = CODE_XOFF;
        endcase
        return res;
    endfunction

endpackage

// File: hw/rtl/ebfr_byte_if.sv
// ----------------------------------------------------------------------------
// ebfr_byte_if
// Raw line byte channel, valid/ready.
// ----------------------------------------------------------------------------
interface ebfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;

    modport source (output valid, output raw_byte, input ready);
    modport sink   (input valid, input raw_byte, output ready);
endinterface

// File: hw/rtl/ebfr_result_if.sv
// ----------------------------------------------------------------------------
// ebfr_result_if
// Decoded result word channel, valid/ready.
// ----------------------------------------------------------------------------
interface ebfr_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] payload_offset;
    logic [15:0] message_length;
    logic        last;

    modport source (output valid, output kind, output data_byte, output payload_offset,
                    output message_length, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input payload_offset,
                    input message_length, input last, output ready);
endinterface

// File: hw/rtl/ebfr_decode.sv
// ----------------------------------------------------------------------------
// ebfr_decode
// Next state and result for one raw byte.
// ----------------------------------------------------------------------------
module ebfr_decode import ebfr_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    output t_state     o_state,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic        is_data;
    logic [7:0]  data;
    logic        is_last;

    assign is_last = (i_state.idx == ({1'b0, i_state.len} + 17'd1));

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;
        is_data     = 1'b0;
        data        = i_byte;

        // control and escape decode
        if (i_byte == CODE_RESET) begin
            o_state.mode = MODE_IDLE;
        end else if (i_byte == CODE_ESC) begin
            o_state.esc = 1'b1;
        end else if (!i_state.esc) begin
            is_data = 1'b1;
        end else begin
            o_state.esc = 1'b0;
            if (i_byte inside {[ESC_DATA_MIN:ESC_DATA_MAX]}) begin
                is_data = 1'b1;
                data    = unescape(i_byte[1:0]);
            end else begin
                case (i_byte)
                    ESC_MSG: begin
                        o_state.mode = MODE_MESSAGE;
                        o_state.idx  = '0;
                        o_state.len  = '0;
                    end
                    ESC_SSTART: begin
                        o_state.mode = MODE_STREAM;
                        o_res_valid  = 1'b1;
                        o_res.kind   = KIND_STREAM_START;
                    end
                    ESC_SSTOP: begin
                        o_state.mode = MODE_IDLE;
                        o_res_valid  = 1'b1;
                        o_res.kind   = KIND_STREAM_STOP;
                    end
                    default: ;
                endcase
            end
        end

        // data byte handling by mode
        if (is_data) begin
            case (i_state.mode)
                MODE_STREAM: begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_STREAM_DATA;
                    o_res.data_byte = data;
                end
                MODE_MESSAGE: begin
                    if (i_state.idx == 17'd0) begin
                        o_state.len = {data, 8'h00};
                        o_state.idx = 17'd1;
                    end else if (i_state.idx == 17'd1) begin
                        o_state.len = i_state.len | {8'h00, data};
                        if ((i_state.len | {8'h00, data}) == 16'd0) begin
                            o_state.mode = MODE_IDLE;
                            o_state.idx  = '0;
                            o_res_valid  = 1'b1;
                            o_res.kind   = KIND_EMPTY_MSG;
                            o_res.last   = 1'b1;
                        end else begin
                            o_state.idx = 17'd2;
                        end
                    end else begin
                        o_res_valid          = 1'b1;
                        o_res.kind           = KIND_MSG_BYTE;
                        o_res.data_byte      = data;
                        o_res.payload_offset = 16'(i_state.idx - 17'd2);
                        o_res.message_length = i_state.len;
                        o_res.last           = is_last;
                        if (is_last) begin
                            o_state.mode = MODE_IDLE;
                            o_state.idx  = '0;
                        end else begin
                            o_state.idx = i_state.idx + 17'd1;
                        end
                    end
                end
                default: ;  // idle or unused mode: drop
            endcase
        end
    end

endmodule

// File: hw/rtl/ebfr_outq.sv
// ----------------------------------------------------------------------------
// ebfr_outq
// Two-word output queue: output register plus skid entry.
// ----------------------------------------------------------------------------
module ebfr_outq import ebfr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_pop_ready
);

    logic    r_q0_valid, r_q1_valid;
    logic    n_q0_valid, n_q1_valid;
    t_result r_q0, r_q1;
    t_result n_q0, n_q1;
    logic    pop;

    assign pop     = r_q0_valid && i_pop_ready;
    assign o_full  = r_q1_valid;
    assign o_valid = r_q0_valid;
    assign o_data  = r_q0;

    always_comb begin
        n_q0_valid = r_q0_valid;
        n_q1_valid = r_q1_valid;
        n_q0       = r_q0;
        n_q1       = r_q1;
        if (pop) begin
            if (r_q1_valid) begin
                n_q0       = r_q1;
                n_q1       = i_data;
                n_q1_valid = i_push;
            end else begin
                n_q0       = i_data;
                n_q0_valid = i_push;
            end
        end else if (i_push) begin
            if (!r_q0_valid) begin
                n_q0       = i_data;
                n_q0_valid = 1'b1;
            end else begin
                n_q1       = i_data;
                n_q1_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q0_valid <= 1'b0;
            r_q1_valid <= 1'b0;
        end else begin
            r_q0_valid <= n_q0_valid;
            r_q1_valid <= n_q1_valid;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

// File: hw/rtl/escaped_byte_frame_receiver.sv
// ----------------------------------------------------------------------------
// escaped_byte_frame_receiver
// Byte-stuffed line deframer: streams, length-prefixed messages, controls.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : raw line bytes (valid/ready), one word per byte from the link.
//   o_out : decoded result words (kind, data_byte, payload_offset,
//           message_length, last). Bytes that yield nothing (control codes,
//           length bytes, bytes while idle) are consumed silently.
//   Order: results are registered in the output queue, behind any queued word.
//   Throughput: one byte per cycle unless the output queue is full; the decode
//   is one combinational pass from the state registers into the output queue.
//   Stall: a two-word output queue (output register + skid entry) decouples
//   the sides; input ready drops only while both entries hold words, so a
//   word waiting on o_out does not block the next byte.
//   Reset (i_rst_n low, synchronous): receiver idle, escape flag clear,
//   message counters zero, output queue empty.
// ----------------------------------------------------------------------------
module escaped_byte_frame_receiver import ebfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ebfr_byte_if.sink   i_in,
    ebfr_result_if.source o_out
);

    t_state  r_state;
    t_state  n_state;
    logic    res_valid;
    t_result res;
    t_result q_data;
    logic    q_full;
    logic    accept;

    // ready depends only on queue occupancy
    assign i_in.ready = !q_full;
    assign accept     = i_in.valid && !q_full;

    ebfr_decode u_decode (
        .i_state     (r_state),
        .i_byte      (i_in.raw_byte),
        .o_state     (n_state),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // receiver state advances once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.esc  <= 1'b0;
            r_state.mode <= MODE_IDLE;
            r_state.idx  <= '0;
            r_state.len  <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    ebfr_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept && res_valid),
        .i_data      (res),
        .o_full      (q_full),
        .o_valid     (o_out.valid),
        .o_data      (q_data),
        .i_pop_ready (o_out.ready)
    );

    assign o_out.kind           = q_data.kind;
    assign o_out.data_byte      = q_data.data_byte;
    assign o_out.payload_offset = q_data.payload_offset;
    assign o_out.message_length = q_data.message_length;
    assign o_out.last           = q_data.last;

endmodule

// File: dv/tb_escaped_byte_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_escaped_byte_frame_receiver
// Self-checking bench: drives escaped line bytes, predicts the decoded words
// and checks every result word field by field, in order.
// ----------------------------------------------------------------------------
module tb_escaped_byte_frame_receiver import ebfr_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // escape codes that stand for the four reserved data bytes
    localparam logic [7:0] ESC_FOR_RESET = ESC_DATA_MIN;
    localparam logic [7:0] ESC_FOR_ESC   = 8'h02;
    localparam logic [7:0] ESC_FOR_XON   = 8'h03;
    localparam logic [7:0] ESC_FOR_XOFF  = ESC_DATA_MAX;

    localparam int unsigned STALL_LIMIT   = 5000; // cycles with no word moving
    localparam int unsigned RANDOM_ITEMS  = 600;
    localparam int unsigned LONG_HOLD_AT  = 60;   // result count that forces a long hold
    localparam int unsigned DRAIN_CYCLES  = 8;

    // one queued line byte, or a marker that holds the sender until all
    // expected words have come out
    typedef struct packed {
        bit       wait_drain;
        bit [7:0] raw_byte;
    } t_line_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ebfr_byte_if   in_if ();
    ebfr_result_if out_if ();

    escaped_byte_frame_receiver u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    t_line_word  line_q[$];
    t_result     expected_results[$];
    t_line_word  next_word;
    t_result     predicted;
    t_result     want;

    int unsigned errors       = 0;
    int unsigned results_seen = 0;
    int unsigned stall_cycles = 0;
    int unsigned src_gap_left = 0;
    int unsigned hold_left    = 0;
    bit          src_burst    = 1'b0;
    bit          sink_burst   = 1'b0;
    bit          long_hold_done = 1'b0;
    bit          in_taken     = 1'b0;

    // ------------------------------------------------------------------
    // Deframer prediction. State starts at its reset values; reset is
    // applied once before any byte, so no explicit clear is needed.
    // ------------------------------------------------------------------
    bit        rx_esc  = 1'b0;
    t_mode     rx_mode = MODE_IDLE;
    bit [16:0] rx_idx  = '0;
    bit [15:0] rx_len  = '0;

    // a data byte (plain or unescaped) as seen by the current mode
    function automatic bit take_data(input bit [7:0] d, output t_result res);
        bit hit;
        res = '0;
        hit = 1'b0;
        case (rx_mode)
            MODE_STREAM: begin
                res.kind      = KIND_STREAM_DATA;
                res.data_byte = d;
                hit           = 1'b1;
            end
            MODE_MESSAGE: begin
                if (rx_idx == 17'd0) begin
                    // high length byte
                    rx_len = {d, 8'h00};
                    rx_idx = 17'd1;
                end else if (rx_idx == 17'd1) begin
                    rx_len[7:0] = d;
                    if (rx_len == 16'd0) begin
                        rx_mode  = MODE_IDLE;
                        rx_idx   = '0;
                        res.kind = KIND_EMPTY_MSG;
                        res.last = 1'b1;
                        hit      = 1'b1;
                    end else begin
                        rx_idx = 17'd2;
                    end
                end else begin
                    res.kind           = KIND_MSG_BYTE;
                    res.data_byte      = d;
                    res.payload_offset = 16'(rx_idx - 17'd2);
                    res.message_length = rx_len;
                    res.last           = (rx_idx == {1'b0, rx_len} + 17'd1);
                    hit                = 1'b1;
                    if (res.last) begin
                        // message done: back to idle, later data is dropped
                        rx_mode = MODE_IDLE;
                        rx_idx  = '0;
                    end else begin
                        rx_idx = rx_idx + 17'd1;
                    end
                end
            end
            default: ; // idle (and the unused mode) drops the byte
        endcase
        return hit;
    endfunction

    function automatic bit decode_line_byte(input bit [7:0] b, output t_result res);
        res = '0;
        // line reset goes idle but keeps a pending escape
        if (b == CODE_RESET) begin
            rx_mode = MODE_IDLE;
            return 1'b0;
        end
        if (b == CODE_ESC) begin
            rx_esc = 1'b1;
            return 1'b0;
        end
        if (!rx_esc)
            return take_data(b, res);
        rx_esc = 1'b0;
        case (b)
            ESC_FOR_RESET: return take_data(CODE_RESET, res);
            ESC_FOR_ESC:   return take_data(CODE_ESC, res);
            ESC_FOR_XON:   return take_data(CODE_XON, res);
            ESC_FOR_XOFF:  return take_data(CODE_XOFF, res);
            ESC_MSG: begin
                // obeyed in any mode; abandons whatever was in progress
                rx_mode = MODE_MESSAGE;
                rx_idx  = '0;
                rx_len  = '0;
                return 1'b0;
            end
            ESC_SSTART: begin
                rx_mode  = MODE_STREAM;
                res.kind = KIND_STREAM_START;
                return 1'b1;
            end
            ESC_SSTOP: begin
                // stop is emitted even when no stream is open
                rx_mode  = MODE_IDLE;
                res.kind = KIND_STREAM_STOP;
                return 1'b1;
            end
            default: return 1'b0; // unknown escape: flag cleared, nothing else
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers: they only queue line bytes for the driver.
    // ------------------------------------------------------------------
    task automatic send_raw(input bit [7:0] b);
        line_q.push_back('{1'b0, b});
    endtask

    task automatic send_cmd(input bit [7:0] code);
        send_raw(CODE_ESC);
        send_raw(code);
    endtask

    task automatic pause_sender();
        line_q.push_back('{1'b1, 8'h00});
    endtask

    // reserved bytes must be escaped; XON/XOFF may go either way
    task automatic send_data(input bit [7:0] d);
        bit [7:0] code;
        bit       can_escape;
        bit       must_escape;
        code        = '0;
        can_escape  = 1'b1;
        must_escape = 1'b0;
        case (d)
            CODE_RESET: begin code = ESC_FOR_RESET; must_escape = 1'b1; end
            CODE_ESC:   begin code = ESC_FOR_ESC;   must_escape = 1'b1; end
            CODE_XON:   code = ESC_FOR_XON;
            CODE_XOFF:  code = ESC_FOR_XOFF;
            default:    can_escape = 1'b0;
        endcase
        if (can_escape && (must_escape || $urandom_range(0, 1) == 1))
            send_cmd(code);
        else
            send_raw(d);
    endtask

    // payload byte with the reserved values drawn often
    function automatic bit [7:0] random_payload();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return CODE_RESET;
            1:       return CODE_ESC;
            2:       return CODE_XON;
            3:       return CODE_XOFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // message header with len, followed by n_bytes payload bytes (n_bytes < len
    // leaves the message open for the caller to break)
    task automatic send_message(input bit [15:0] len, input int unsigned n_bytes);
        send_cmd(ESC_MSG);
        send_data(len[15:8]);
        send_data(len[7:0]);
        for (int unsigned i = 0; i < n_bytes; i++)
            send_data(random_payload());
    endtask

    task automatic send_stream(input int unsigned n_bytes, input bit close);
        send_cmd(ESC_SSTART);
        for (int unsigned i = 0; i < n_bytes; i++)
            send_data(random_payload());
        if (close)
            send_cmd(ESC_SSTOP);
    endtask

    // gap length for either side: mostly none, some short, a few long;
    // burst stretches run with no gaps at all
    function automatic int unsigned pick_gap(inout bit burst);
        int unsigned r;
        if ($urandom_range(0, 149) == 0)
            burst = !burst;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] exp_val,
                                   input logic [15:0] got_val);
        $display("ERROR @%0t: %s: expected 0x%0h, got 0x%0h", $realtime, what,
                 exp_val, got_val);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Sender: presents queued bytes at the falling edge, holds a word until
    // it is taken, then waits out a random gap. A drain marker keeps valid
    // low until every expected word has left the block.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (src_gap_left != 0) begin
                src_gap_left <= src_gap_left - 1;
                in_if.valid  <= 1'b0;
            end else if (line_q.size() == 0) begin
                in_if.valid <= 1'b0;
            end else if (line_q[0].wait_drain) begin
                if (expected_results.size() == 0)
                    next_word = line_q.pop_front();
                in_if.valid <= 1'b0;
            end else begin
                next_word       = line_q.pop_front();
                in_if.valid    <= 1'b1;
                in_if.raw_byte <= next_word.raw_byte;
                src_gap_left   <= pick_gap(src_burst);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random ready, plus one forced long hold once traffic is
    // flowing (and rare extra ones) so the output queue fills and the
    // block has to drop its input ready.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else if ((results_seen >= LONG_HOLD_AT && !long_hold_done) ||
                     $urandom_range(0, 3999) == 0) begin
            long_hold_done <= 1'b1;
            hold_left      <= $urandom_range(100, 200);
            out_if.ready   <= 1'b0;
        end else begin
            hold_left    <= pick_gap(sink_burst);
            out_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted byte, checks every accepted word
    // against the oldest prediction. Expectations are queued before the
    // check so ordering holds even for a same-cycle result.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_if.valid && in_if.ready;
            if (in_if.valid && in_if.ready) begin
                if (decode_line_byte(in_if.raw_byte, predicted))
                    expected_results.push_back(predicted);
            end
            if (out_if.valid && out_if.ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with none pending, kind", '0, out_if.kind);
                end else begin
                    want = expected_results.pop_front();
                    if (out_if.kind !== want.kind)
                        report_mismatch("kind", want.kind, out_if.kind);
                    if (out_if.data_byte !== want.data_byte)
                        report_mismatch("data_byte", want.data_byte, out_if.data_byte);
                    if (out_if.payload_offset !== want.payload_offset)
                        report_mismatch("payload_offset", want.payload_offset,
                                        out_if.payload_offset);
                    if (out_if.message_length !== want.message_length)
                        report_mismatch("message_length", want.message_length,
                                        out_if.message_length);
                    if (out_if.last !== want.last)
                        report_mismatch("last", want.last, out_if.last);
                end
            end
        end
    end

    // watchdog: ends the run if no word moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan and end of test
    // ------------------------------------------------------------------
    initial begin
        int unsigned counted;
        int unsigned mark;
        int unsigned r;
        int unsigned n;
        bit [15:0]   len;

        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.raw_byte = '0;
        out_if.ready   = 1'b0;

        // --- directed part ---
        send_raw(8'h00);                 // data while idle: dropped
        send_raw(8'hFF);
        send_cmd(ESC_SSTART);            // stream start
        send_raw(8'h00);                 // extremes pass through
        send_raw(8'hFF);
        send_cmd(ESC_FOR_RESET);         // escaped data inside a stream
        send_cmd(ESC_FOR_XOFF);
        send_raw(CODE_ESC);              // line reset keeps the pending escape,
        send_raw(CODE_RESET);            // so the stop below is still escaped;
        send_raw(ESC_SSTOP);             // stop outside a stream
        send_cmd(8'h07);                 // unknown escape
        send_cmd(ESC_MSG);               // zero-length message
        send_raw(8'h00);
        send_raw(8'h00);
        send_message(16'd2, 0);          // two-byte message, escaped payload
        send_cmd(ESC_FOR_ESC);
        send_cmd(ESC_FOR_XON);
        send_raw(8'h99);                 // after the end of a message: dropped
        send_message(16'd5, 1);          // start in a wrong mode abandons it
        send_cmd(ESC_SSTART);
        pause_sender();

        // --- random part: mostly well-formed frames, some noise and breakage ---
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            mark = line_q.size();
            r    = $urandom_range(0, 99);
            if (r < 40) begin
                n = $urandom_range(0, 99);
                if (n < 8)
                    len = 16'd0;
                else if (n < 78)
                    len = 16'($urandom_range(1, 8));
                else if (n < 96)
                    len = 16'($urandom_range(9, 40));
                else
                    len = 16'($urandom_range(200, 300));
                if (len != 0 && $urandom_range(0, 9) == 0) begin
                    // broken message: cut short, then reset or restart
                    send_message(len, $urandom_range(0, len - 1));
                    case ($urandom_range(0, 2))
                        0:       send_raw(CODE_RESET);
                        1:       send_cmd(ESC_SSTART);
                        default: send_cmd(ESC_MSG);
                    endcase
                end else begin
                    send_message(len, len);
                end
            end else if (r < 70) begin
                n = $urandom_range(0, 12);
                if ($urandom_range(0, 6) == 0) begin
                    send_stream(n, 1'b0);
                    send_raw(CODE_RESET);
                end else begin
                    send_stream(n, 1'b1);
                end
            end else if (r < 80) begin
                // line noise; not counted
                n = $urandom_range(1, 6);
                for (int unsigned i = 0; i < n; i++)
                    send_raw(8'($urandom_range(0, 255)));
                mark = line_q.size();
            end else if (r < 90) begin
                case ($urandom_range(0, 2))
                    0: send_cmd(8'($urandom_range(0, 255)));  // any escaped value
                    1: begin                                   // double escape
                        send_raw(CODE_ESC);
                        send_cmd(ESC_SSTART);
                    end
                    default: begin                             // reset between escape and code
                        send_raw(CODE_ESC);
                        send_raw(CODE_RESET);
                        send_raw(ESC_SSTOP);
                    end
                endcase
            end else if (r < 95) begin
                send_cmd(ESC_SSTOP);
            end else begin
                pause_sender();
            end
            counted += line_q.size() - mark;
        end

        // release reset on a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all bytes taken, all words out, then a DRAIN_CYCLES wait for strays
        while (line_q.size() != 0 || in_if.valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
